/* design/pidc_pkg.sv */
// pidc_pkg: shared types and constants of the dual form pid controller
// holds field widths, reset values and register, form and clamp codes
// no dependencies
package pidc_pkg;

  localparam int unsigned GAIN_WIDTH        = 16;
  localparam int unsigned DRIVE_WIDTH       = 16;
  localparam int unsigned HIT_WIDTH         = 2;
  localparam int unsigned CFG_IDX_WIDTH     = 3;
  localparam int unsigned CFG_DATA_WIDTH    = 16;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned GAIN_FRAC_DEF     = 8;
  localparam int unsigned ACC_WIDTH_DEF     = 40;
  localparam logic [DRIVE_WIDTH-1:0] DRIVE_LIMIT_RESET = DRIVE_WIDTH'(16000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_PID_FORM    = 3'd0,
    CFG_GAIN_P      = 3'd1,
    CFG_GAIN_I      = 3'd2,
    CFG_GAIN_D      = 3'd3,
    CFG_DRIVE_LIMIT = 3'd4
  } cfg_idx_e;

  // controller form
  typedef enum logic {
    FORM_INCREMENTAL = 1'b0,
    FORM_POSITIONAL  = 1'b1
  } pid_form_e;

  // clamp status of a result
  typedef enum logic [HIT_WIDTH-1:0] {
    HIT_NONE  = 2'd0,
    HIT_LIMIT = 2'd1,
    HIT_ZERO  = 2'd2
  } limit_hit_e;

endpackage

/* design/pid_controller_dual_form_unit.sv */
// pid_controller_dual_form_unit: top level of the dual form pid controller
// one input register, single pass gain arithmetic and clamp, one result register
// depends on pidc_pkg
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   -------------------------
//  cfg       in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//  in        in         in_valid_i/in_ready_o   setpoint_i, measured_i
//  out       out        out_valid_o/out_ready_i drive_o, limit_hit_o
//
// a transaction is taken into the input register and its result is registered in
// the result register when it advances; one transaction per cycle is sustained while
// out_ready_i is high; the path between is three gain multipliers feeding one
// three-input add, a shift, the base add and the clamp compare
// reset clears the valid flags, the gains and the loop state; drive_limit resets to 16000
// a stalled result holds in the result register while the input register keeps
// its transaction; in_ready_o drops only when both are full and out_ready_i is low
module pid_controller_dual_form_unit
  import pidc_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = GAIN_FRAC_DEF,
  parameter int unsigned ACC_WIDTH      = ACC_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_WIDTH-1:0]      cfg_wdata_i,
  // control samples
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] setpoint_i,
  input  logic signed [SAMPLE_WIDTH-1:0] measured_i,
  // drive results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [DRIVE_WIDTH-1:0]         drive_o,
  output logic [HIT_WIDTH-1:0]           limit_hit_o
);

  // error, operand, product and sum widths
  localparam int unsigned EW  = SAMPLE_WIDTH + 1;             // error
  localparam int unsigned DW  = SAMPLE_WIDTH + 3;             // second difference
  localparam int unsigned PW  = GAIN_WIDTH + DW;              // gain product
  localparam int unsigned MW  = (ACC_WIDTH > PW) ? ACC_WIDTH : PW;
  localparam int unsigned SW  = MW + 2;                       // three-term sum
  localparam int unsigned VW  = SW + 1;                       // with last drive

  // configuration registers
  pid_form_e                     pid_form_q;
  logic signed [GAIN_WIDTH-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [DRIVE_WIDTH-1:0]        drive_limit_q;

  // input register
  logic                          in_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] setpoint_q, measured_q;

  // loop state
  logic signed [EW-1:0]          error_prev_q, error_prev_prev_q;
  logic signed [ACC_WIDTH-1:0]   integral_q, integral_d;
  logic [DRIVE_WIDTH-1:0]        last_drive_q;

  // result register
  logic                          out_valid_q;
  logic [DRIVE_WIDTH-1:0]        drive_q, drive_d;
  limit_hit_e                    hit_q, hit_d;

  logic                          advance;

  // datapath
  logic signed [EW-1:0]          err0;
  logic signed [DW-1:0]          diff1, diff2, op_p, op_d, op_i;
  logic signed [PW-1:0]          prod_p, prod_i, prod_d;
  logic signed [SW-1:0]          integ_sum, integ_ext, term_c, sum_all, sum_shr;
  logic                          integ_ovf;
  logic signed [VW-1:0]          base, value, limit_ext;

  //--------------------------------------------------------------------------
  // handshake: the input register moves on whenever the result register is
  // free or is being emptied in the same cycle
  //--------------------------------------------------------------------------
  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign drive_o     = drive_q;
  assign limit_hit_o = hit_q;

  //--------------------------------------------------------------------------
  // configuration writes, out-of-range indexes fall through
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pid_form_q    <= FORM_INCREMENTAL;
      gain_p_q      <= '0;
      gain_i_q      <= '0;
      gain_d_q      <= '0;
      drive_limit_q <= DRIVE_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PID_FORM:    pid_form_q    <= pid_form_e'(cfg_wdata_i[0]);
        CFG_GAIN_P:      gain_p_q      <= $signed(cfg_wdata_i[GAIN_WIDTH-1:0]);
        CFG_GAIN_I:      gain_i_q      <= $signed(cfg_wdata_i[GAIN_WIDTH-1:0]);
        CFG_GAIN_D:      gain_d_q      <= $signed(cfg_wdata_i[GAIN_WIDTH-1:0]);
        CFG_DRIVE_LIMIT: drive_limit_q <= cfg_wdata_i[DRIVE_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // error terms
  //--------------------------------------------------------------------------
  assign err0  = EW'(setpoint_q) - EW'(measured_q);
  assign diff1 = DW'(err0) - DW'(error_prev_q);
  assign diff2 = DW'(err0) - (DW'(error_prev_q) <<< 1) + DW'(error_prev_prev_q);

  // the multipliers are shared by both forms, only their operands change:
  // incremental  p*(e0-e1) + i*e0 + d*(e0-2e1+e2)
  // positional   p*e0 + i*e0 (into the integral) + d*(e0-e1)
  always_comb begin
    op_i = DW'(err0);
    if (pid_form_q == FORM_POSITIONAL) begin
      op_p = DW'(err0);
      op_d = diff1;
    end else begin
      op_p = diff1;
      op_d = diff2;
    end
  end

  assign prod_p = gain_p_q * op_p;
  assign prod_i = gain_i_q * op_i;
  assign prod_d = gain_d_q * op_d;

  //--------------------------------------------------------------------------
  // saturating integral: overflow when the bits above the accumulator's sign
  // bit disagree with the sign of the exact sum
  //--------------------------------------------------------------------------
  assign integ_sum = SW'(integral_q) + SW'(prod_i);
  assign integ_ovf = (integ_sum[SW-1:ACC_WIDTH-1] != {(SW-ACC_WIDTH+1){1'b0}})
                  && (integ_sum[SW-1:ACC_WIDTH-1] != {(SW-ACC_WIDTH+1){1'b1}});

  always_comb begin
    if (integ_ovf) begin
      integral_d = {integ_sum[SW-1], {(ACC_WIDTH-1){!integ_sum[SW-1]}}};
    end else begin
      integral_d = integ_sum[ACC_WIDTH-1:0];
    end
  end

  assign integ_ext = SW'(integral_d);

  //--------------------------------------------------------------------------
  // sum, floor shift and the incremental base
  //--------------------------------------------------------------------------
  assign term_c  = (pid_form_q == FORM_POSITIONAL) ? integ_ext : SW'(prod_i);
  assign sum_all = SW'(prod_p) + SW'(prod_d) + term_c;
  assign sum_shr = sum_all >>> GAIN_FRAC_BITS;

  assign base      = (pid_form_q == FORM_POSITIONAL) ? '0
                     : VW'($signed({1'b0, last_drive_q}));
  assign value     = VW'(sum_shr) + base;
  assign limit_ext = VW'($signed({1'b0, drive_limit_q}));

  // clamp to zero .. drive_limit
  always_comb begin
    if (value > limit_ext) begin
      drive_d = drive_limit_q;
      hit_d   = HIT_LIMIT;
    end else if (value[VW-1]) begin
      drive_d = '0;
      hit_d   = HIT_ZERO;
    end else begin
      drive_d = value[DRIVE_WIDTH-1:0];
      hit_d   = HIT_NONE;
    end
  end

  //--------------------------------------------------------------------------
  // control registers and loop state
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
      error_prev_q      <= '0;
      error_prev_prev_q <= '0;
      integral_q        <= '0;
      last_drive_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        error_prev_prev_q <= error_prev_q;
        error_prev_q      <= err0;
        last_drive_q      <= drive_d;
        if (pid_form_q == FORM_POSITIONAL) begin
          integral_q <= integral_d;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      setpoint_q <= setpoint_i;
      measured_q <= measured_i;
    end
    if (advance) begin
      drive_q <= drive_d;
      hit_q   <= hit_d;
    end
  end

endmodule
